/* design/eow_pkg.sv */
// Shared types and constants for the elimination-order width block.
// No dependencies; used by eow_seq and elimination_order_width.
package eow_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int OP_W             = 2;
    localparam int VERTEX_W         = 6;
    localparam int WIDTH_W          = 6;

    typedef enum logic [OP_W-1:0] {
        OP_EDGE   = 2'd0,
        OP_ELIM   = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // Finish report handed from the sequencer to the output stage.
    typedef struct packed {
        logic               vld;
        logic [WIDTH_W-1:0] width;
    } t_report;

endpackage

/* design/eow_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module eow_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/eow_seq.sv */
// Sequencer: vertex masks, counters and read-modify-write of adjacency rows.
// Depends on eow_pkg; drives the adjacency RAM ports of the top level.
module eow_seq #(
    parameter int MAX_VERTICES = eow_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [eow_pkg::OP_W-1:0]          i_op,
    input  logic [eow_pkg::VERTEX_W-1:0]      i_vertex_a,
    input  logic [eow_pkg::VERTEX_W-1:0]      i_vertex_b,
    output logic                              o_idle,
    output eow_pkg::t_report                  o_report,
    output logic                              o_mem_we,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_mem_waddr,
    output logic [MAX_VERTICES-1:0]           o_mem_wdata,
    output logic                              o_mem_re,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_mem_raddr,
    input  logic [MAX_VERTICES-1:0]           i_mem_rdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = eow_pkg::VERTEX_W + 1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EDGE_A   = 6'b000010,
        S_EDGE_B   = 6'b000100,
        S_ELIM_ROW = 6'b001000,
        S_SCAN     = 6'b010000,
        S_TAIL     = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [MAX_VERTICES-1:0] r_seen, n_seen;
    logic [MAX_VERTICES-1:0] r_elim, n_elim;
    logic [MAX_VERTICES-1:0] r_row_vld, n_row_vld;
    logic [CW-1:0]           r_total, n_total;
    logic [CW-1:0]           r_elims, n_elims;
    logic [VW-1:0]           r_max, n_max;
    logic [VW-1:0]           r_a, n_a;
    logic [VW-1:0]           r_b, n_b;
    logic [MAX_VERTICES-1:0] r_live, n_live;
    logic [VW-1:0]           r_idx, n_idx;
    logic [VW-1:0]           r_deg, n_deg;
    logic                    r_wb_vld, n_wb_vld;
    logic [VW-1:0]           r_wb_addr, n_wb_addr;
    logic                    r_rd_vld, n_rd_vld;

    logic [VW-1:0]           ia, ib;
    logic                    a_ok, b_ok, seen_a, seen_b, new_a, new_b;
    logic [MAX_VERTICES-1:0] bit_a, bit_b, bit_ra, bit_rb, bit_wb;
    logic [MAX_VERTICES-1:0] rd_row, wb_data;
    logic [CW-1:0]           left, width_full;
    logic                    wb_hit;

    assign ia     = i_vertex_a[VW-1:0];
    assign ib     = i_vertex_b[VW-1:0];
    assign a_ok   = {1'b0, i_vertex_a} < CMP_W'(MAX_VERTICES);
    assign b_ok   = {1'b0, i_vertex_b} < CMP_W'(MAX_VERTICES);
    assign bit_a  = MAX_VERTICES'(1) << ia;
    assign bit_b  = MAX_VERTICES'(1) << ib;
    assign bit_ra = MAX_VERTICES'(1) << r_a;
    assign bit_rb = MAX_VERTICES'(1) << r_b;
    assign bit_wb = MAX_VERTICES'(1) << r_wb_addr;
    assign seen_a = |(r_seen & bit_a);
    assign seen_b = |(r_seen & bit_b);
    assign new_a  = !seen_a;
    assign new_b  = !seen_b && (ia != ib);

    // A row never written since the last clear reads as zero.
    assign rd_row  = r_rd_vld ? i_mem_rdata : '0;
    assign wb_data = (rd_row | r_live) & ~bit_wb & ~bit_ra;
    assign wb_hit  = r_wb_vld && r_live[r_wb_addr];

    assign left       = (r_total > r_elims) ? (r_total - r_elims) : '0;
    assign width_full = (left != '0 && (left - CW'(1)) > CW'(r_max)) ?
                        (left - CW'(1)) : CW'(r_max);

    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_elim      = r_elim;
        n_row_vld   = r_row_vld;
        n_total     = r_total;
        n_elims     = r_elims;
        n_max       = r_max;
        n_a         = r_a;
        n_b         = r_b;
        n_live      = r_live;
        n_idx       = r_idx;
        n_deg       = r_deg;
        n_wb_vld    = r_wb_vld;
        n_wb_addr   = r_wb_addr;
        n_rd_vld    = r_rd_vld;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        o_report    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_acc) begin
                    unique case (eow_pkg::t_op'(i_op))
                        eow_pkg::OP_EDGE: begin
                            if (a_ok && b_ok) begin
                                n_seen  = r_seen | bit_a | bit_b;
                                n_total = r_total + CW'(new_a) + CW'(new_b);
                                if (ia != ib && (r_elim & (bit_a | bit_b)) == '0) begin
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = ia;
                                    n_rd_vld    = r_row_vld[ia];
                                    n_a         = ia;
                                    n_b         = ib;
                                    n_state     = S_EDGE_A;
                                end
                            end
                        end
                        eow_pkg::OP_ELIM: begin
                            if (a_ok && seen_a && (r_elim & bit_a) == '0) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = ia;
                                n_rd_vld    = r_row_vld[ia];
                                n_a         = ia;
                                n_state     = S_ELIM_ROW;
                            end
                        end
                        eow_pkg::OP_FINISH: begin
                            o_report.vld   = 1'b1;
                            o_report.width = eow_pkg::WIDTH_W'(width_full);
                            n_seen         = '0;
                            n_elim         = '0;
                            n_row_vld      = '0;
                            n_total        = '0;
                            n_elims        = '0;
                            n_max          = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE_A: begin
                o_mem_we       = 1'b1;
                o_mem_waddr    = r_a;
                o_mem_wdata    = rd_row | bit_rb;
                n_row_vld[r_a] = 1'b1;
                o_mem_re       = 1'b1;
                o_mem_raddr    = r_b;
                n_rd_vld       = r_row_vld[r_b];
                n_state        = S_EDGE_B;
            end
            S_EDGE_B: begin
                o_mem_we       = 1'b1;
                o_mem_waddr    = r_b;
                o_mem_wdata    = rd_row | bit_ra;
                n_row_vld[r_b] = 1'b1;
                n_state        = S_IDLE;
            end
            S_ELIM_ROW: begin
                n_live   = rd_row & r_seen & ~r_elim & ~bit_ra;
                n_idx    = '0;
                n_deg    = '0;
                n_wb_vld = 1'b0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_idx;
                n_rd_vld    = r_row_vld[r_idx];
                n_wb_vld    = 1'b1;
                n_wb_addr   = r_idx;
                n_deg       = r_deg + VW'(r_live[r_idx]);
                if (wb_hit) begin
                    o_mem_we             = 1'b1;
                    o_mem_waddr          = r_wb_addr;
                    o_mem_wdata          = wb_data;
                    n_row_vld[r_wb_addr] = 1'b1;
                end
                if (r_idx == VW'(MAX_VERTICES - 1)) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + VW'(1);
                end
            end
            S_TAIL: begin
                if (wb_hit) begin
                    o_mem_we             = 1'b1;
                    o_mem_waddr          = r_wb_addr;
                    o_mem_wdata          = wb_data;
                    n_row_vld[r_wb_addr] = 1'b1;
                end
                n_wb_vld = 1'b0;
                if (r_deg > r_max) begin
                    n_max = r_deg;
                end
                // Drop the eliminated row by invalidating it.
                n_row_vld[r_a] = 1'b0;
                n_elim         = r_elim | bit_ra;
                n_elims        = r_elims + CW'(1);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_elim    <= '0;
            r_row_vld <= '0;
            r_total   <= '0;
            r_elims   <= '0;
            r_max     <= '0;
            r_wb_vld  <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seen    <= n_seen;
            r_elim    <= n_elim;
            r_row_vld <= n_row_vld;
            r_total   <= n_total;
            r_elims   <= n_elims;
            r_max     <= n_max;
            r_wb_vld  <= n_wb_vld;
            r_rd_vld  <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_live    <= n_live;
        r_idx     <= n_idx;
        r_deg     <= n_deg;
        r_wb_addr <= n_wb_addr;
    end

    assign o_idle = (r_state == S_IDLE);

    a_no_rw_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("row read and written in the same cycle");

    a_elim_subset_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_elim & ~r_seen) == '0) && (r_elims <= r_total))
        else $error("eliminated vertex not seen or count overrun");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report.vld |=> (r_seen == '0 && r_row_vld == '0 && r_total == '0 && r_max == '0))
        else $error("finish did not clear the store");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELIM_ROW) |=> (r_state == S_SCAN && r_idx == '0 && !r_wb_vld))
        else $error("neighbor scan did not start at row zero");

endmodule

/* design/elimination_order_width.sv */
// Elimination-order width of an undirected graph held in an adjacency RAM.
// Takes items one at a time: an add-edge item reads and writes back both
// endpoint rows; an eliminate item reads the row of the vertex, then gives one
// read-modify-write slot per RAM row while the fill edges are merged into every
// live neighbor; a finish item leaves the sequencer idle. The single read and
// single write port of the adjacency RAM set these steps. Out-of-range vertices,
// repeated or unseen eliminations and op code 3 are ignored and leave the
// sequencer idle; a self loop or an edge to an eliminated vertex only marks its
// endpoints as seen. A finish item produces one result item with the width and
// clears the store at once: rows carry valid bits, so there is no clearing pass
// after reset or after finish. The result waits in an output register; while it
// waits and the receiver stalls, input is held, so the next item is taken at the
// earliest in the cycle in which the width is collected.
// Depends on eow_pkg, eow_ram and eow_seq.
module elimination_order_width #(
    parameter int MAX_VERTICES = eow_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [eow_pkg::OP_W-1:0]     i_op,
    input  logic [eow_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [eow_pkg::VERTEX_W-1:0] i_vertex_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [eow_pkg::WIDTH_W-1:0]  o_width
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic                        in_acc;
    logic                        seq_idle;
    eow_pkg::t_report            report;
    logic                        mem_we, mem_re;
    logic [VW-1:0]               mem_waddr, mem_raddr;
    logic [MAX_VERTICES-1:0]     mem_wdata, mem_rdata;

    logic                        r_out_vld, n_out_vld;
    logic [eow_pkg::WIDTH_W-1:0] r_width, n_width;

    // Hold input while the sequencer works on an item, or while a result waits
    // and is not taken in this cycle (a finish would have nowhere to go).
    assign o_stall = !seq_idle || (r_out_vld && i_stall);
    assign in_acc  = i_valid && !o_stall;

    eow_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    eow_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_op        (i_op),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_idle      (seq_idle),
        .o_report    (report),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Load a new result on finish, otherwise drop the held one once taken.
    always_comb begin
        n_out_vld = r_out_vld;
        n_width   = r_width;
        if (report.vld) begin
            n_out_vld = 1'b1;
            n_width   = report.width;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width <= n_width;
    end

    assign o_valid = r_out_vld;
    assign o_width = r_width;

    a_report_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        report.vld |-> (in_acc && i_op == eow_pkg::OP_FINISH))
        else $error("report without an accepted finish item");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !report.vld)
        else $error("pending result overwritten");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !seq_idle |-> !in_acc)
        else $error("item accepted while sequencer busy");

endmodule
